@@ hdl/tridiagonal_system_solver_assert.svh @@
// Assertion macros for the tridiagonal system solver
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_ASSERT_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_ASSERT_SVH
// same-cycle implication
`define TDS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define TDS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`endif

@@ hdl/tds_pkg.sv @@
// Shared types, constants and saturation functions of the tridiagonal solver
package tds_pkg;
	localparam int MAX_ROWS_DEF = 64;
	localparam int DW = 48;
	localparam int ROW_W = 6;

	typedef logic signed [DW-1:0] data_t;

	typedef struct packed {
		logic done;
		logic ovf;
		logic zdiv;
	} arith_sts_t;

	function automatic logic [DW:0] pack_f(input logic neg, input logic [63:0] m);
		logic [63:0] nm;
		logic [DW:0] r;
		nm = ~m + 64'd1;
		if (neg) begin
			if (m > 64'h0000_8000_0000_0000) r = {1'b1, 48'h8000_0000_0000};
			else r = {1'b0, nm[DW-1:0]};
		end else begin
			if (m > 64'h0000_7FFF_FFFF_FFFF) r = {1'b1, 48'h7FFF_FFFF_FFFF};
			else r = {1'b0, m[DW-1:0]};
		end
		return r;
	endfunction

	function automatic logic [DW:0] sub_f(input data_t x, input data_t y);
		logic signed [DW:0] d;
		logic [DW:0] r;
		d = 49'(x) - 49'(y);
		if (d[DW] != d[DW-1]) r = d[DW] ? {1'b1, 48'h8000_0000_0000} : {1'b1, 48'h7FFF_FFFF_FFFF};
		else r = {1'b0, d[DW-1:0]};
		return r;
	endfunction
endpackage

@@ hdl/tridiagonal_system_solver.sv @@
// Top level of the Thomas-algorithm tridiagonal solver: sequencer and row stores
//
// channel  direction  handshake           payload
// rows     in         in_valid/in_stall   sub_diag main_diag super_diag rhs last_row
// results  out        out_valid/out_stall solution row_index last_result zero_pivot overflow
//
// After its transfer a row runs two divisions and two multiplications on one shared
// divider and one shared multiplier; row 0 needs one division, and a zero divisor
// ends a division without running the quotient loop.
// The last row adds one multiplication per earlier row for back substitution,
// then gives the results in row order, each held while out_stall is high.
// in_stall is high from each row transfer until that row (or the system) is done.
// arst_n clears the sequencer, row count, pivot and flags; the stores need no clear.
module tridiagonal_system_solver #(
	parameter int MAX_ROWS = tds_pkg::MAX_ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [tds_pkg::DW-1:0] sub_diag,
	input  logic signed [tds_pkg::DW-1:0] main_diag,
	input  logic signed [tds_pkg::DW-1:0] super_diag,
	input  logic signed [tds_pkg::DW-1:0] rhs,
	input  logic                        last_row,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [tds_pkg::DW-1:0] solution,
	output logic [tds_pkg::ROW_W-1:0]   row_index,
	output logic                        last_result,
	output logic                        zero_pivot,
	output logic                        overflow
);
	`include "tridiagonal_system_solver_assert.svh"

	localparam int IDXW = $clog2(MAX_ROWS);
	localparam int DW = tds_pkg::DW;

	typedef enum logic [3:0] {
		S_IDLE, S_G_GO, S_G_WT, S_AG_GO, S_AG_WT, S_AU_GO, S_AU_WT,
		S_U_GO, S_U_WT, S_B_RD, S_B_GO, S_B_WT, S_E_RD, S_E_WT
	} state_t;

	state_t              state_q;
	logic [IDXW-1:0]     row_cnt_q;
	logic [IDXW-1:0]     j_q;
	logic [IDXW-1:0]     k_q;
	logic                fin_q;
	logic                zp_q;
	logic                ov_q;
	tds_pkg::data_t      a_q, b_q, c_q, t_q, g_q, pivot_q, psd_q, cur_q;
	tds_pkg::data_t      gam_mem [MAX_ROWS];
	tds_pkg::data_t      ps_mem [MAX_ROWS];
	tds_pkg::data_t      gam_rd_q, ps_rd_q;

	logic                mul_start, div_start;
	tds_pkg::data_t      mul_a, mul_b, div_x, mul_res, div_res;
	tds_pkg::arith_sts_t mul_sts, div_sts;
	tds_pkg::data_t      sub_x;
	logic [DW:0]         sub_r;
	logic                gam_we, ps_we;
	logic [IDXW-1:0]     ps_wa;
	tds_pkg::data_t      ps_wd;

	assign mul_start = (state_q == S_AG_GO) || (state_q == S_AU_GO) || (state_q == S_B_GO);
	assign div_start = (state_q == S_G_GO) || (state_q == S_U_GO);
	assign mul_a = (state_q == S_B_GO) ? gam_rd_q : a_q;
	assign mul_b = (state_q == S_AG_GO) ? g_q : cur_q;
	assign div_x = (state_q == S_G_GO) ? psd_q : t_q;

	tds_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.x(mul_a), .y(mul_b), .res(mul_res), .sts(mul_sts)
	);

	tds_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.x(div_x), .y(pivot_q), .res(div_res), .sts(div_sts)
	);

	assign sub_x = (state_q == S_AG_WT) ? b_q : ((state_q == S_AU_WT) ? t_q : ps_rd_q);
	assign sub_r = tds_pkg::sub_f(sub_x, mul_res);

	assign gam_we = (state_q == S_G_WT) && div_sts.done;
	assign ps_we = ((state_q == S_U_WT) && div_sts.done) || ((state_q == S_B_WT) && mul_sts.done);
	assign ps_wa = (state_q == S_U_WT) ? j_q : k_q;
	assign ps_wd = (state_q == S_U_WT) ? div_res : sub_r[DW-1:0];

	always_ff @(posedge clk) begin
		if (gam_we) gam_mem[j_q] <= div_res;
		if (ps_we) ps_mem[ps_wa] <= ps_wd;
		gam_rd_q <= gam_mem[k_q + IDXW'(1)];
		ps_rd_q <= ps_mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_cnt_q <= '0;
			pivot_q <= '0;
			psd_q <= '0;
			zp_q <= 1'b0;
			ov_q <= 1'b0;
			k_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						a_q <= sub_diag;
						b_q <= main_diag;
						c_q <= super_diag;
						t_q <= rhs;
						j_q <= row_cnt_q;
						fin_q <= last_row || (row_cnt_q == IDXW'(MAX_ROWS - 1));
						if (row_cnt_q == '0) begin
							pivot_q <= main_diag;
							state_q <= S_U_GO;
						end else begin
							state_q <= S_G_GO;
						end
					end
				end
				S_G_GO: state_q <= S_G_WT;
				S_G_WT: begin
					if (div_sts.done) begin
						g_q <= div_res;
						zp_q <= zp_q | div_sts.zdiv;
						ov_q <= ov_q | div_sts.ovf;
						state_q <= S_AG_GO;
					end
				end
				S_AG_GO: state_q <= S_AG_WT;
				S_AG_WT: begin
					if (mul_sts.done) begin
						pivot_q <= sub_r[DW-1:0];
						ov_q <= ov_q | mul_sts.ovf | sub_r[DW];
						state_q <= S_AU_GO;
					end
				end
				S_AU_GO: state_q <= S_AU_WT;
				S_AU_WT: begin
					if (mul_sts.done) begin
						t_q <= sub_r[DW-1:0];
						ov_q <= ov_q | mul_sts.ovf | sub_r[DW];
						state_q <= S_U_GO;
					end
				end
				S_U_GO: state_q <= S_U_WT;
				S_U_WT: begin
					if (div_sts.done) begin
						cur_q <= div_res;
						psd_q <= c_q;
						zp_q <= zp_q | div_sts.zdiv;
						ov_q <= ov_q | div_sts.ovf;
						if (!fin_q) begin
							row_cnt_q <= j_q + IDXW'(1);
							state_q <= S_IDLE;
						end else if (j_q == '0) begin
							k_q <= '0;
							state_q <= S_E_RD;
						end else begin
							k_q <= j_q - IDXW'(1);
							state_q <= S_B_RD;
						end
					end
				end
				S_B_RD: state_q <= S_B_GO;
				S_B_GO: state_q <= S_B_WT;
				S_B_WT: begin
					if (mul_sts.done) begin
						cur_q <= sub_r[DW-1:0];
						ov_q <= ov_q | mul_sts.ovf | sub_r[DW];
						if (k_q == '0) begin
							state_q <= S_E_RD;
						end else begin
							k_q <= k_q - IDXW'(1);
							state_q <= S_B_RD;
						end
					end
				end
				S_E_RD: state_q <= S_E_WT;
				S_E_WT: begin
					if (!out_stall) begin
						if (k_q == j_q) begin
							row_cnt_q <= '0;
							pivot_q <= '0;
							psd_q <= '0;
							zp_q <= 1'b0;
							ov_q <= 1'b0;
							k_q <= '0;
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + IDXW'(1);
							state_q <= S_E_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_E_WT);
	assign solution = ps_rd_q;
	assign row_index = tds_pkg::ROW_W'(k_q);
	assign last_result = (k_q == j_q);
	assign zero_pivot = zp_q;
	assign overflow = ov_q;

	`TDS_ASSERT_NOW(a_no_accept_while_emit, clk, arst_n, out_valid, in_stall, "row accepted during result output")
	`TDS_ASSERT_NXT(a_idle_after_last, clk, arst_n, out_valid && !out_stall && last_result, !in_stall, "not idle after last result")
	`TDS_ASSERT_NXT(a_flags_steady, clk, arst_n, out_valid && !out_stall && !last_result, $stable(zero_pivot) && $stable(overflow), "flags changed within a system")
endmodule

@@ hdl/tds_mul.sv @@
// Shift-add Q16.32 multiplier with rounding and saturation
module tds_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tds_pkg::data_t      x,
	input  tds_pkg::data_t      y,
	output tds_pkg::data_t      res,
	output tds_pkg::arith_sts_t sts
);
	localparam int DW = tds_pkg::DW;

	typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

	mstate_t             state_q;
	logic [5:0]          cnt_q;
	logic                neg_q;
	logic [DW-1:0]       mcand_q;
	logic [DW-1:0]       mpl_q;
	logic [DW-1:0]       acc_q;
	tds_pkg::data_t      res_q;
	tds_pkg::arith_sts_t sts_q;
	logic [DW:0]         sum;
	logic [63:0]         m;
	logic [DW:0]         pk;
	logic [DW-1:0]       mag_x;
	logic [DW-1:0]       mag_y;

	assign mag_x = x[DW-1] ? (~x + 1'b1) : x;
	assign mag_y = y[DW-1] ? (~y + 1'b1) : y;
	assign sum = {1'b0, acc_q} + (mpl_q[0] ? {1'b0, mcand_q} : '0);
	assign m = {acc_q, mpl_q[DW-1:32]} + 64'(mpl_q[31]);
	assign pk = tds_pkg::pack_f(neg_q, m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			sts_q <= '0;
			cnt_q <= '0;
		end else begin
			sts_q.done <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						neg_q <= x[DW-1] ^ y[DW-1];
						mcand_q <= mag_x;
						mpl_q <= mag_y;
						acc_q <= '0;
						cnt_q <= '0;
						state_q <= M_RUN;
					end
				end
				M_RUN: begin
					{acc_q, mpl_q} <= {sum, mpl_q[DW-1:1]};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DW-1)) state_q <= M_FIN;
				end
				M_FIN: begin
					res_q <= pk[DW-1:0];
					sts_q <= '{done: 1'b1, ovf: pk[DW], zdiv: 1'b0};
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign res = res_q;
	assign sts = sts_q;
endmodule

@@ hdl/tds_div.sv @@
// Restoring Q16.32 divider with rounding, saturation and zero-divisor detect
module tds_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tds_pkg::data_t      x,
	input  tds_pkg::data_t      y,
	output tds_pkg::data_t      res,
	output tds_pkg::arith_sts_t sts
);
	localparam int DW = tds_pkg::DW;

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

	dstate_t             state_q;
	logic [6:0]          i_q;
	logic                neg_q;
	logic                big_q;
	logic [DW-1:0]       d_q;
	logic [79:0]         dvd_q;
	logic [DW-1:0]       rem_q;
	logic [DW-1:0]       q_q;
	tds_pkg::data_t      res_q;
	tds_pkg::arith_sts_t sts_q;
	logic [DW:0]         rs;
	logic [DW:0]         diff;
	logic                ge;
	logic                inc;
	logic [DW:0]         q49;
	logic [63:0]         m;
	logic [DW:0]         pk;
	logic [DW-1:0]       mag_x;
	logic [DW-1:0]       mag_y;

	assign mag_x = x[DW-1] ? (~x + 1'b1) : x;
	assign mag_y = y[DW-1] ? (~y + 1'b1) : y;
	assign rs = {rem_q, dvd_q[79]};
	assign diff = rs - {1'b0, d_q};
	assign ge = rs >= {1'b0, d_q};
	assign inc = {1'b0, rem_q} >= ({1'b0, d_q} - {1'b0, rem_q});
	assign q49 = {1'b0, q_q} + 49'(inc);
	assign m = big_q ? (64'd1 << DW) : 64'(q49);
	assign pk = tds_pkg::pack_f(neg_q, m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			sts_q <= '0;
			i_q <= '0;
		end else begin
			sts_q.done <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						if (y == '0) begin
							res_q <= '0;
							sts_q <= '{done: 1'b1, ovf: 1'b0, zdiv: 1'b1};
						end else begin
							neg_q <= x[DW-1] ^ y[DW-1];
							d_q <= mag_y;
							dvd_q <= {mag_x, 32'd0};
							rem_q <= '0;
							q_q <= '0;
							big_q <= 1'b0;
							i_q <= 7'd79;
							state_q <= D_RUN;
						end
					end
				end
				D_RUN: begin
					rem_q <= ge ? diff[DW-1:0] : rs[DW-1:0];
					dvd_q <= {dvd_q[78:0], 1'b0};
					q_q <= {q_q[DW-2:0], ge};
					if (ge && i_q >= 7'(DW)) big_q <= 1'b1;
					i_q <= i_q - 7'd1;
					if (i_q == '0) state_q <= D_FIN;
				end
				D_FIN: begin
					res_q <= pk[DW-1:0];
					sts_q <= '{done: 1'b1, ovf: pk[DW], zdiv: 1'b0};
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign res = res_q;
	assign sts = sts_q;
endmodule

@@ tb/sv/tridiagonal_system_solver_tb.sv @@
// Self-checking testbench for the tridiagonal system solver: random and directed row streams
module tridiagonal_system_solver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NROWS = tds_pkg::MAX_ROWS_DEF;
	localparam int DW = tds_pkg::DW;
	localparam int IDLE_LIMIT = 40000;
	localparam logic [63:0] POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MAX = 64'h0000_8000_0000_0000;

	typedef struct {
		logic [DW-1:0] a;
		logic [DW-1:0] b;
		logic [DW-1:0] c;
		logic [DW-1:0] r;
		logic          last;
	} row_t;

	typedef struct {
		logic [DW-1:0]            sol;
		logic [tds_pkg::ROW_W-1:0] idx;
		logic                     last;
		logic                     zp;
		logic                     ov;
	} soln_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [DW-1:0] sub_diag = '0;
	logic signed [DW-1:0] main_diag = '0;
	logic signed [DW-1:0] super_diag = '0;
	logic signed [DW-1:0] rhs = '0;
	logic last_row = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DW-1:0] solution;
	logic [tds_pkg::ROW_W-1:0] row_index;
	logic last_result;
	logic zero_pivot;
	logic overflow;

	row_t rows[$];
	soln_t expected_solutions[$];
	int rows_taken = 0;
	int cur = 0;
	bit busy = 0;
	int gap_left = 0;
	int burst_left = 1;
	int stall_pct = 0;
	int stall_phase = 0;
	int idle_cycles = 0;
	int errors = 0;
	bit stim_done = 0;

	longint gam[NROWS];
	longint part[NROWS];
	longint piv = 0;
	longint prev_c = 0;
	int row_cnt = 0;
	bit flag_zp = 0;
	bit flag_ov = 0;

	tridiagonal_system_solver DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sub_diag(sub_diag), .main_diag(main_diag), .super_diag(super_diag),
		.rhs(rhs), .last_row(last_row), .out_valid(out_valid), .out_stall(out_stall),
		.solution(solution), .row_index(row_index), .last_result(last_result),
		.zero_pivot(zero_pivot), .overflow(overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sext(input logic [DW-1:0] v);
		return longint'({{16{v[DW-1]}}, v});
	endfunction

	function automatic logic [63:0] mag(input longint x);
		return (x < 0) ? 64'(-x) : 64'(x);
	endfunction

	function automatic longint fx_pack(input bit neg, input logic [63:0] m);
		logic [63:0] v;
		v = m;
		if (neg) begin
			if (v > NEG_MAX) begin
				flag_ov = 1;
				v = NEG_MAX;
			end
			return -longint'(v);
		end
		if (v > POS_MAX) begin
			flag_ov = 1;
			v = POS_MAX;
		end
		return longint'(v);
	endfunction

	function automatic longint fx_sub(input longint x, input longint y);
		longint d;
		d = x - y;
		return fx_pack(d < 0, mag(d));
	endfunction

	function automatic longint fx_mul(input longint x, input longint y);
		logic [127:0] p;
		p = {64'd0, mag(x)} * {64'd0, mag(y)} + 128'h8000_0000;
		return fx_pack((x < 0) != (y < 0), p[95:32]);
	endfunction

	function automatic longint fx_div(input longint x, input longint y);
		logic [127:0] num;
		logic [127:0] d;
		logic [127:0] q;
		logic [127:0] rem;
		logic [63:0] qq;
		if (y == 0) begin
			flag_zp = 1;
			return 0;
		end
		num = {64'd0, mag(x)} << 32;
		d = {64'd0, mag(y)};
		q = num / d;
		rem = num % d;
		if (q >= (128'd1 << 48)) qq = 64'd1 << 48;
		else begin
			qq = q[63:0];
			if (rem >= d - rem) qq = qq + 64'd1;
		end
		return fx_pack((x < 0) != (y < 0), qq);
	endfunction

	task automatic solve_row(input row_t x);
		longint a, b, c, r, u, g;
		int j, n;
		soln_t s;
		a = sext(x.a);
		b = sext(x.b);
		c = sext(x.c);
		r = sext(x.r);
		j = (row_cnt >= NROWS) ? NROWS - 1 : row_cnt;
		if (j == 0) begin
			piv = b;
			u = fx_div(r, piv);
		end else begin
			g = fx_div(prev_c, piv);
			gam[j] = g;
			piv = fx_sub(b, fx_mul(a, g));
			u = fx_div(fx_sub(r, fx_mul(a, part[j-1])), piv);
		end
		part[j] = u;
		prev_c = c;
		if (!x.last && j < NROWS - 1) begin
			row_cnt = j + 1;
			return;
		end
		n = j + 1;
		for (int k = n - 2; k >= 0; k--)
			part[k] = fx_sub(part[k], fx_mul(gam[k+1], part[k+1]));
		for (int k = 0; k < n; k++) begin
			s.sol = part[k][DW-1:0];
			s.idx = k[tds_pkg::ROW_W-1:0];
			s.last = (k == n - 1);
			s.zp = flag_zp;
			s.ov = flag_ov;
			expected_solutions.insert(expected_solutions.size(), s);
		end
		row_cnt = 0;
		piv = 0;
		prev_c = 0;
		flag_zp = 0;
		flag_ov = 0;
	endtask

	function automatic logic [DW-1:0] rnd48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[DW-1:0];
	endfunction

	function automatic logic [DW-1:0] rnd_signed(input int bits);
		logic [63:0] v;
		v = {$urandom, $urandom} & ((64'd1 << bits) - 1);
		if ($urandom_range(0, 1)) v = -v;
		return v[DW-1:0];
	endfunction

	task automatic add_row(input logic [DW-1:0] a, b, c, r, input logic last);
		row_t x;
		x.a = a;
		x.b = b;
		x.c = c;
		x.r = r;
		x.last = last;
		rows.insert(rows.size(), x);
	endtask

	task automatic add_system(input int n, input int kind, input bit flag_end);
		logic [DW-1:0] b;
		for (int i = 0; i < n; i++) begin
			if (kind == 0) begin
				b = rnd_signed($urandom_range(33, 38));
				add_row(rnd_signed($urandom_range(20, 33)), b,
					rnd_signed($urandom_range(20, 33)),
					rnd_signed($urandom_range(20, 44)), flag_end && (i == n - 1));
			end else
				add_row(rnd48(), rnd48(), rnd48(), rnd48(), flag_end && (i == n - 1));
		end
	endtask

	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			solve_row(rows[rows_taken]);
			rows_taken <= rows_taken + 1;
		end
		if (out_valid && !out_stall) begin
			if (expected_solutions.size() == 0) begin
				$display("%0t: unexpected result row %0d solution %h", $time, row_index,
					solution);
				errors++;
			end else begin
				soln_t e;
				e = expected_solutions.pop_front();
				if (solution !== e.sol)
					$display("%0t: solution exp %h act %h", $time, e.sol, solution);
				if (row_index !== e.idx)
					$display("%0t: row_index exp %0d act %0d", $time, e.idx, row_index);
				if (last_result !== e.last)
					$display("%0t: last_result exp %b act %b", $time, e.last, last_result);
				if (zero_pivot !== e.zp)
					$display("%0t: zero_pivot exp %b act %b", $time, e.zp, zero_pivot);
				if (overflow !== e.ov)
					$display("%0t: overflow exp %b act %b", $time, e.ov, overflow);
				if (solution !== e.sol || row_index !== e.idx || last_result !== e.last
					|| zero_pivot !== e.zp || overflow !== e.ov)
					errors++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end else
			idle_cycles = 0;
	end

	always @(negedge clk) begin
		if (arst_n && stim_done) begin
			if (busy && rows_taken > cur) begin
				cur++;
				busy = 0;
			end
			if (!busy) begin
				if (gap_left > 0) gap_left--;
				else if (cur < rows.size()) begin
					busy = 1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
					end
				end
			end
			in_valid <= busy;
			if (busy) begin
				sub_diag <= rows[cur].a;
				main_diag <= rows[cur].b;
				super_diag <= rows[cur].c;
				rhs <= rows[cur].r;
				last_row <= rows[cur].last;
			end
		end
		stall_phase++;
		if (stall_phase >= 300) begin
			stall_phase = 0;
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 30;
				2: stall_pct = 70;
				default: stall_pct = 95;
			endcase
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		add_row(48'h0001_0000_0000, 48'h0002_0000_0000, 48'h0, 48'h0004_0000_0000, 1'b1);
		add_row(48'h0, 48'h7FFF_FFFF_FFFF, 48'h0, 48'h7FFF_FFFF_FFFF, 1'b1);
		add_row(48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF,
			48'h8000_0000_0000, 1'b1);
		add_row(48'h0, 48'h0000_0000_0001, 48'h0, 48'h7FFF_FFFF_FFFF, 1'b1);
		add_row(48'h0, 48'h0, 48'h0, 48'h0001_0000_0000, 1'b1);
		add_row(48'h0, 48'h0000_0000_0003, 48'h0, 48'h0000_0000_0001, 1'b1);
		add_row(48'h0, 48'h0000_0000_0003, 48'h0, 48'h0000_0000_0002, 1'b1);
		add_row(48'h0, 48'h0, 48'h0001_0000_0000, 48'h0001_0000_0000, 1'b0);
		add_row(48'h0001_0000_0000, 48'h0002_0000_0000, 48'h0, 48'h0001_0000_0000, 1'b1);
		add_row(48'h0, 48'h0001_0000_0000, 48'h0001_0000_0000, 48'h0, 1'b0);
		add_row(48'h0001_0000_0000, 48'h0001_0000_0000, 48'h0001_0000_0000,
			48'h0001_0000_0000, 1'b0);
		add_row(48'h0001_0000_0000, 48'h0003_0000_0000, 48'h0, 48'h0002_0000_0000, 1'b1);
		add_row(48'h0, 48'h0000_0000_0001, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b0);
		add_row(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h0, 48'h8000_0000_0000, 1'b1);
		add_system(4, 0, 1);
		add_system(3, 1, 1);
		while (rows.size() < 300) begin
			if ($urandom_range(0, 4) == 0) add_system($urandom_range(1, 6), 1, 1);
			else add_system($urandom_range(1, 8), 0, 1);
		end
		add_system(NROWS, 0, 0);
		add_system(3, 0, 1);
		add_system(NROWS, 1, 1);
		burst_left = $urandom_range(1, 8);
		stim_done = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (cur < rows.size() || expected_solutions.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_solutions.size() == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
